/* rtl/lias_pkg.sv */
// ----------------------------------------------------------------------------
// lias_pkg
// Shared types and constants for the local interval alignment score unit.
// ----------------------------------------------------------------------------
package lias_pkg;

    localparam int MAX_TARGETS = 256;
    localparam int IDX_W       = $clog2(MAX_TARGETS);
    localparam int COL_W       = $clog2(MAX_TARGETS + 1);
    localparam int SCORE_W     = 24;
    localparam int MZ_W        = 32;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MATCH_BONUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_TARGET  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_SOURCE  = 2'd2;

    localparam logic [CFG_W-1:0] CFG_RESET_VALUE = 16'd256;

    localparam logic REQ_TARGET = 1'b0;
    localparam logic REQ_SOURCE = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_ROW
    } state_t;

    typedef struct packed {
        logic               valid;
        logic               last;
        logic [SCORE_W-1:0] diag;
        logic [SCORE_W-1:0] left;
        logic [SCORE_W-1:0] best;
        logic [COL_W-1:0]   col;
        logic [COL_W-1:0]   pos;
    } token_t;

endpackage

/* rtl/local_interval_alignment_score_unit.sv */
// ----------------------------------------------------------------------------
// local_interval_alignment_score_unit
// Local interval alignment scorer built as a chain of target-column cells.
//
// Channel   Dir  Beat contents
// s_axis    in   tuser: req_type; tdata: mz_low [31:0], mz_high [63:32];
//                tlast: is_last
// m_axis    out  tuser: found; tdata: best_score [23:0], best_column [32:24]
// cfg       in   cfg_index selects register, cfg_data is the value
//
// A source beat passes through the inject register, then moves along the
// chain one cell per cycle.
// Reset empties the target set and zeroes all row scores.
// A pending result blocks new input beats until it is taken.
// ----------------------------------------------------------------------------
module local_interval_alignment_score_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [63:0]                      s_axis_tdata,  // mz_low, mz_high
    input  logic [0:0]                       s_axis_tuser,  // req_type
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [39:0]                      m_axis_tdata,  // best_score, best_column
    output logic [0:0]                       m_axis_tuser,  // found
    input  logic                             cfg_wr_en,
    input  logic [lias_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lias_pkg::CFG_W-1:0]       cfg_data
);

    localparam int N = lias_pkg::MAX_TARGETS;

    lias_pkg::state_t state_reg;
    lias_pkg::state_t state_next;

    logic [lias_pkg::CFG_W-1:0]  bonus_reg;
    logic [lias_pkg::CFG_W-1:0]  tpen_reg;
    logic [lias_pkg::CFG_W-1:0]  spen_reg;
    logic [lias_pkg::COL_W-1:0]  count_reg;
    logic                        complete_reg;
    logic [lias_pkg::MZ_W-1:0]   src_low_reg;
    logic [lias_pkg::MZ_W-1:0]   src_high_reg;
    lias_pkg::token_t            inject_reg;
    lias_pkg::token_t            inject_next;
    lias_pkg::token_t            chain [0:N];

    logic                        out_valid_reg;
    logic                        out_found_reg;
    logic [lias_pkg::SCORE_W-1:0] out_score_reg;
    logic [lias_pkg::COL_W-1:0]  out_col_reg;

    logic                        accept;
    logic                        is_target;
    logic                        start_row;
    logic                        new_set;
    logic                        ld_en;
    logic [lias_pkg::IDX_W-1:0]  ld_index;
    logic                        row_done;

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign is_target = (s_axis_tuser[0] == lias_pkg::REQ_TARGET);
    assign start_row = accept && !is_target && complete_reg;
    assign new_set   = accept && is_target && complete_reg;
    assign ld_en     = accept && is_target
                       && (complete_reg || (count_reg < lias_pkg::COL_W'(N)));
    assign ld_index  = complete_reg ? '0 : count_reg[lias_pkg::IDX_W-1:0];
    assign row_done  = chain[N].valid;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lias_pkg::ST_IDLE:
            begin
                if (start_row)
                begin
                    state_next = lias_pkg::ST_ROW;
                end
            end
            lias_pkg::ST_ROW:
            begin
                if (row_done)
                begin
                    state_next = lias_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lias_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        case (state_reg)
            lias_pkg::ST_IDLE: s_axis_tready = !out_valid_reg;
            lias_pkg::ST_ROW:  s_axis_tready = 1'b0;
            default:           s_axis_tready = 1'b0;
        endcase
    end

    always_comb
    begin
        inject_next       = '0;
        inject_next.valid = start_row;
        inject_next.last  = s_axis_tlast;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lias_pkg::ST_IDLE;
            bonus_reg     <= lias_pkg::CFG_RESET_VALUE;
            tpen_reg      <= lias_pkg::CFG_RESET_VALUE;
            spen_reg      <= lias_pkg::CFG_RESET_VALUE;
            count_reg     <= '0;
            complete_reg  <= 1'b0;
            inject_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            inject_reg <= inject_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    lias_pkg::REG_MATCH_BONUS: bonus_reg <= cfg_data;
                    lias_pkg::REG_SKIP_TARGET: tpen_reg  <= cfg_data;
                    lias_pkg::REG_SKIP_SOURCE: spen_reg  <= cfg_data;
                    default:                   ;
                endcase
            end
            if (accept && is_target)
            begin
                if (new_set)
                begin
                    count_reg <= lias_pkg::COL_W'(1);
                end
                else if (ld_en)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                complete_reg <= s_axis_tlast;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (row_done && chain[N].last)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_row)
        begin
            src_low_reg  <= s_axis_tdata[31:0];
            src_high_reg <= s_axis_tdata[63:32];
        end
        if (row_done && chain[N].last)
        begin
            out_found_reg <= (chain[N].best != '0);
            out_score_reg <= chain[N].best;
            out_col_reg   <= chain[N].col;
        end
    end

    assign chain[0] = inject_reg;

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            lias_cell u_cell (
                .clk                 (clk),
                .rst_n               (rst_n),
                .cell_index          (lias_pkg::IDX_W'(gi)),
                .clr                 (new_set),
                .ld_en               (ld_en),
                .ld_index            (ld_index),
                .ld_low              (s_axis_tdata[31:0]),
                .ld_high             (s_axis_tdata[63:32]),
                .src_low             (src_low_reg),
                .src_high            (src_high_reg),
                .match_bonus         (bonus_reg),
                .skip_target_penalty (tpen_reg),
                .skip_source_penalty (spen_reg),
                .tok_in              (chain[gi]),
                .tok_out             (chain[gi + 1])
            );
        end
    endgenerate

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tdata  = {{(40 - lias_pkg::SCORE_W - lias_pkg::COL_W){1'b0}},
                            out_col_reg, out_score_reg};

endmodule

/* rtl/lias_cell.sv */
// ----------------------------------------------------------------------------
// lias_cell
// One target column: holds its interval and row score, updates on the token.
// ----------------------------------------------------------------------------
module lias_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [lias_pkg::IDX_W-1:0]          cell_index,
    input  logic                                clr,
    input  logic                                ld_en,
    input  logic [lias_pkg::IDX_W-1:0]          ld_index,
    input  logic [lias_pkg::MZ_W-1:0]           ld_low,
    input  logic [lias_pkg::MZ_W-1:0]           ld_high,
    input  logic [lias_pkg::MZ_W-1:0]           src_low,
    input  logic [lias_pkg::MZ_W-1:0]           src_high,
    input  logic [lias_pkg::CFG_W-1:0]          match_bonus,
    input  logic [lias_pkg::CFG_W-1:0]          skip_target_penalty,
    input  logic [lias_pkg::CFG_W-1:0]          skip_source_penalty,
    input  lias_pkg::token_t                    tok_in,
    output lias_pkg::token_t                    tok_out
);

    localparam int SW = lias_pkg::SCORE_W;
    localparam int PW = SW - lias_pkg::CFG_W;

    logic [lias_pkg::MZ_W-1:0] low_reg;
    logic [lias_pkg::MZ_W-1:0] high_reg;
    logic                      loaded_reg;
    logic [SW-1:0]             score_reg;
    lias_pkg::token_t          tok_reg;
    lias_pkg::token_t          tok_next;

    logic          overlap;
    logic [SW:0]   diag_sum;
    logic [SW-1:0] diag_val;
    logic [SW-1:0] left_val;
    logic [SW-1:0] up_val;
    logic [SW-1:0] tpen;
    logic [SW-1:0] spen;
    logic [SW-1:0] cell_val;
    logic [lias_pkg::COL_W-1:0] pos_inc;

    always_comb
    begin
        tpen     = {{PW{1'b0}}, skip_target_penalty};
        spen     = {{PW{1'b0}}, skip_source_penalty};
        overlap  = (src_low <= high_reg) && (low_reg <= src_high);
        diag_sum = {1'b0, tok_in.diag} + {{(PW + 1){1'b0}}, match_bonus};
        diag_val = '0;
        if (overlap)
        begin
            diag_val = diag_sum[SW] ? {SW{1'b1}} : diag_sum[SW-1:0];
        end
        left_val = (tok_in.left > tpen) ? (tok_in.left - tpen) : '0;
        up_val   = (score_reg > spen) ? (score_reg - spen) : '0;
        cell_val = diag_val;
        if (left_val > cell_val)
        begin
            cell_val = left_val;
        end
        if (up_val > cell_val)
        begin
            cell_val = up_val;
        end
    end

    always_comb
    begin
        pos_inc      = tok_in.pos + 1'b1;
        tok_next     = tok_in;
        tok_next.pos = pos_inc;
        if (loaded_reg)
        begin
            tok_next.diag = score_reg;
            tok_next.left = cell_val;
            if (tok_in.last && (cell_val > tok_in.best))
            begin
                tok_next.best = cell_val;
                tok_next.col  = pos_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg    <= '0;
            loaded_reg <= 1'b0;
            score_reg  <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (clr)
            begin
                loaded_reg <= 1'b0;
                score_reg  <= '0;
            end
            if (ld_en && (ld_index == cell_index))
            begin
                loaded_reg <= 1'b1;
            end
            if (tok_in.valid && loaded_reg)
            begin
                score_reg <= tok_in.last ? '0 : cell_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_en && (ld_index == cell_index))
        begin
            low_reg  <= ld_low;
            high_reg <= ld_high;
        end
    end

    assign tok_out = tok_reg;

endmodule
